// ===== rtl/rmms_pkg.sv =====
package rmms_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 20;
   localparam int FIELD_BITS      = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_MEAN_FIX,
      ST_SQUARE,
      ST_ACCUM,
      ST_VAR_START,
      ST_VAR_DIV,
      ST_SQRT_START,
      ST_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic mean_start;
      logic div_step;
      logic mean_fix;
      logic square;
      logic accum;
      logic var_start;
      logic sqrt_start;
      logic sqrt_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic full;
   } stat_type;

endpackage

// ===== rtl/running_min_max_mean_std.sv =====
// Running minimum, maximum, mean and standard deviation of signed Q8.8 samples. Every request
// returns one response with the statistics including that sample; once the count is saturated
// the sample is dropped, the statistics stay as they were and count_full is set. Requests are
// handled one at a time: the next acceptance waits until the last request has passed through the
// shared restoring divider, which produces one quotient bit per cycle for the mean
// (SAMPLE_BITS + COUNT_BITS steps) and for the variance (2*SAMPLE_BITS + COUNT_BITS steps), and
// then through the square root unit at one root bit per cycle; a dropped sample skips the
// squaring and accumulation. A finished response waits in the output register while the next
// request is taken; a result that is done while the previous response is still unaccepted
// holds, and delays the next ready, until that response leaves.
module running_min_max_mean_std #(
   parameter int SAMPLE_BITS = rmms_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmms_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rmms_pkg::FIELD_BITS-1:0] req_tdata,  // sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // min_value, max_value, mean_value, std_value, sample_count, zero fill
   output logic [((4 * rmms_pkg::FIELD_BITS + COUNT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [0:0]                      rsp_tuser   // count_full
);

   localparam int RSP_BITS = ((4 * rmms_pkg::FIELD_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int FB       = rmms_pkg::FIELD_BITS;

   rmms_pkg::cmd_type  cmd;
   rmms_pkg::stat_type stat;

   logic [FB-1:0]         min_value, max_value, mean_value, std_value;
   logic [COUNT_BITS-1:0] sample_count;
   logic                  count_full;

   rmms_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rmms_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .sample       (req_tdata),
      .min_value    (min_value),
      .max_value    (max_value),
      .mean_value   (mean_value),
      .std_value    (std_value),
      .sample_count (sample_count),
      .count_full   (count_full)
   );

   assign rsp_tdata = RSP_BITS'({sample_count, std_value, mean_value, max_value, min_value});
   assign rsp_tuser = count_full;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(min_value) <= $signed(max_value)))
      else $error("response minimum above maximum");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (sample_count != '0))
      else $error("response with zero count");

   a_full_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && count_full) |-> (&sample_count))
      else $error("dropped sample flagged below saturated count");

endmodule

// ===== rtl/rmms_ctrl.sv =====
module rmms_ctrl #(
   parameter int SAMPLE_BITS = rmms_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmms_pkg::COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rmms_pkg::stat_type stat,
   output rmms_pkg::cmd_type  cmd
);

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int CNT_BITS = $clog2(SQ_BITS + 1);

   rmms_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmms_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         rmms_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = rmms_pkg::ST_UPDATE;
            end
         end
         rmms_pkg::ST_UPDATE: begin
            cmd.update = !stat.full;
            state_in   = rmms_pkg::ST_MEAN_START;
         end
         rmms_pkg::ST_MEAN_START: begin
            cmd.mean_start = 1'b1;
            cnt_in         = CNT_BITS'(SUM_BITS);
            state_in       = rmms_pkg::ST_MEAN_DIV;
         end
         rmms_pkg::ST_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = rmms_pkg::ST_MEAN_FIX;
            end
         end
         rmms_pkg::ST_MEAN_FIX: begin
            cmd.mean_fix = 1'b1;
            // a saturated count leaves the squared sum alone
            state_in = stat.full ? rmms_pkg::ST_VAR_START : rmms_pkg::ST_SQUARE;
         end
         rmms_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = rmms_pkg::ST_ACCUM;
         end
         rmms_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = rmms_pkg::ST_VAR_START;
         end
         rmms_pkg::ST_VAR_START: begin
            cmd.var_start = 1'b1;
            cnt_in        = CNT_BITS'(SQ_BITS);
            state_in      = rmms_pkg::ST_VAR_DIV;
         end
         rmms_pkg::ST_VAR_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = rmms_pkg::ST_SQRT_START;
            end
         end
         rmms_pkg::ST_SQRT_START: begin
            cmd.sqrt_start = 1'b1;
            cnt_in         = CNT_BITS'(SAMPLE_BITS);
            state_in       = rmms_pkg::ST_SQRT;
         end
         rmms_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = rmms_pkg::ST_DONE;
            end
         end
         rmms_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rmms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmms_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/rmms_dp.sv =====
module rmms_dp #(
   parameter int SAMPLE_BITS = rmms_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmms_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rmms_pkg::cmd_type               cmd,
   output rmms_pkg::stat_type              stat,
   input  logic [rmms_pkg::FIELD_BITS-1:0] sample,
   output logic [rmms_pkg::FIELD_BITS-1:0] min_value,
   output logic [rmms_pkg::FIELD_BITS-1:0] max_value,
   output logic [rmms_pkg::FIELD_BITS-1:0] mean_value,
   output logic [rmms_pkg::FIELD_BITS-1:0] std_value,
   output logic [COUNT_BITS-1:0]           sample_count,
   output logic                            count_full
);

   localparam int SB         = SAMPLE_BITS;
   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS    = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int VAR_BITS   = 2 * SAMPLE_BITS;
   localparam int SREM_BITS  = SAMPLE_BITS + 2;
   localparam int FB         = rmms_pkg::FIELD_BITS;

   // running statistics
   logic signed [SB-1:0]       min_ff, max_ff;
   logic [COUNT_BITS-1:0]      count_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic [SQ_BITS-1:0]         sq_ff;

   // per-request work registers
   logic signed [SB-1:0]       sample_ff;
   logic                       full_ff;
   logic [SQ_BITS-1:0]         div_ff;
   logic [COUNT_BITS-1:0]      rem_ff;
   logic                       neg_ff;
   logic signed [SB-1:0]       mean_ff;
   logic [VAR_BITS-1:0]        prod_ff;
   logic [VAR_BITS-1:0]        var_ff;
   logic [SB-1:0]              root_ff;
   logic [SREM_BITS-1:0]       srem_ff;

   // result register
   logic [FB-1:0]              out_min_ff, out_max_ff, out_mean_ff, out_std_ff;
   logic [COUNT_BITS-1:0]      out_count_ff;
   logic                       out_full_ff;

   logic [SUM_BITS-1:0]        sum_mag;
   logic [COUNT_BITS:0]        div_cat, div_diff;
   logic                       div_ge;
   logic [SB-1:0]              quo;
   logic signed [SB:0]         dev;
   logic [SB:0]                dev_mag;
   logic [VAR_BITS-1:0]        mag_ext;
   logic [SREM_BITS+1:0]       sq_cat, sq_sub, sq_diff;
   logic                       sq_ge;

   always_comb begin
      sum_mag  = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      div_cat  = {rem_ff, div_ff[SQ_BITS-1]};
      div_diff = div_cat - {1'b0, count_ff};
      div_ge   = (div_cat >= {1'b0, count_ff});
      quo      = div_ff[SB-1:0];
      dev      = (SB + 1)'(sample_ff) - (SB + 1)'(mean_ff);
      dev_mag  = dev[SB] ? (SB + 1)'(-dev) : (SB + 1)'(dev);
      mag_ext  = VAR_BITS'(dev_mag[SB-1:0]);
      sq_cat   = {srem_ff, var_ff[VAR_BITS-1 -: 2]};
      sq_sub   = {(SREM_BITS)'(root_ff), 2'b01};
      sq_diff  = sq_cat - sq_sub;
      sq_ge    = (sq_cat >= sq_sub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= {1'b0, {(SB - 1){1'b1}}};
         max_ff   <= {1'b1, {(SB - 1){1'b0}}};
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else begin
         if (cmd.update) begin
            if (sample_ff < min_ff) begin
               min_ff <= sample_ff;
            end
            if (sample_ff > max_ff) begin
               max_ff <= sample_ff;
            end
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_BITS'(sample_ff);
         end
         if (cmd.accum) begin
            sq_ff <= sq_ff + SQ_BITS'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= sample[SB-1:0];
         full_ff   <= &count_ff;
      end
      if (cmd.mean_start) begin
         neg_ff <= sum_ff[SUM_BITS-1];
         div_ff <= {sum_mag, {(SQ_BITS - SUM_BITS){1'b0}}};
         rem_ff <= '0;
      end else if (cmd.var_start) begin
         div_ff <= sq_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         // restoring division, one quotient bit per cycle
         rem_ff <= div_ge ? div_diff[COUNT_BITS-1:0] : div_cat[COUNT_BITS-1:0];
         div_ff <= {div_ff[SQ_BITS-2:0], div_ge};
      end
      if (cmd.mean_fix) begin
         mean_ff <= neg_ff ? -quo : quo;
      end
      if (cmd.square) begin
         prod_ff <= mag_ext * mag_ext;
      end
      if (cmd.sqrt_start) begin
         var_ff  <= div_ff[VAR_BITS-1:0];
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         // bring down two radicand bits, one root bit per cycle
         var_ff  <= {var_ff[VAR_BITS-3:0], 2'b00};
         root_ff <= {root_ff[SB-2:0], sq_ge};
         srem_ff <= sq_ge ? sq_diff[SREM_BITS-1:0] : sq_cat[SREM_BITS-1:0];
      end
      if (cmd.load_out) begin
         out_min_ff   <= FB'(min_ff);
         out_max_ff   <= FB'(max_ff);
         out_mean_ff  <= FB'(mean_ff);
         out_std_ff   <= FB'(root_ff);
         out_count_ff <= count_ff;
         out_full_ff  <= full_ff;
      end
   end

   assign stat.full    = full_ff;
   assign min_value    = out_min_ff;
   assign max_value    = out_max_ff;
   assign mean_value   = out_mean_ff;
   assign std_value    = out_std_ff;
   assign sample_count = out_count_ff;
   assign count_full   = out_full_ff;

endmodule

// ===== sim/tb_running_min_max_mean_std.sv =====
module tb_running_min_max_mean_std;

   localparam int CNT_BITS       = rmms_pkg::COUNT_BITS_DEF;
   localparam int RSP_BITS       = ((4 * rmms_pkg::FIELD_BITS + CNT_BITS + 7) / 8) * 8;
   localparam int RANDOM_SAMPLES = 1800;
   localparam int DRAIN_CYCLES   = 150;
   localparam int MAX_REPORTS    = 10;

   typedef longint unsigned u64_type;

   typedef struct {
      logic [15:0]         min_v;
      logic [15:0]         max_v;
      logic [15:0]         mean_v;
      logic [15:0]         std_v;
      logic [CNT_BITS-1:0] count;
      logic                full;
   } stats_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rmms_pkg::FIELD_BITS-1:0] req_tdata;   // sample
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // min_value, max_value, mean_value, std_value, sample_count, zero fill
   logic [RSP_BITS-1:0]             rsp_tdata;
   logic [0:0]                      rsp_tuser;   // count_full

   // running statistics as the block should hold them
   logic signed [15:0]  run_min    = 16'sh7FFF;
   logic signed [15:0]  run_max    = 16'sh8000;
   logic [CNT_BITS-1:0] run_count  = '0;
   longint              run_sum    = 0;
   u64_type             run_sq_sum = 0;

   logic [rmms_pkg::FIELD_BITS-1:0] sample_queue[$];
   stats_type                       expected_stats[$];
   int                              total_samples  = 0;
   int                              samples_taken  = 0;
   int                              responses_seen = 0;
   int                              mismatch_count = 0;
   logic                            req_taken      = 1'b0;

   running_min_max_mean_std DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic u64_type floor_root(u64_type v);
      u64_type root;
      u64_type trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (u64_type'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // idle percentage by phase: sender light / receiver heavy, then swapped, then none
   function automatic int idle_pct(int done, bit sender);
      if (done < total_samples / 3) return sender ? 15 : 87;
      if (done < (2 * total_samples) / 3) return sender ? 87 : 15;
      return 0;
   endfunction

   task automatic accumulate_sample(input logic [15:0] raw, output stats_type res);
      longint  s;
      longint  mean;
      longint  dev;
      u64_type var_q;
      u64_type root;
      res.full = (run_count == '1);
      if (!res.full) begin
         s = longint'($signed(raw));
         if (s < run_min) run_min = raw;
         if (s > run_max) run_max = raw;
         run_count  = run_count + 1'b1;
         run_sum    = run_sum + s;
         // deviation is taken from the mean that already includes this sample
         mean       = run_sum / longint'(run_count);
         dev        = s - mean;
         run_sq_sum = run_sq_sum + u64_type'(dev * dev);
      end
      mean  = (run_count == 0) ? 0 : run_sum / longint'(run_count);
      var_q = (run_count == 0) ? 0 : run_sq_sum / u64_type'(run_count);
      root  = floor_root(var_q);
      res.min_v  = run_min;
      res.max_v  = run_max;
      res.mean_v = mean[15:0];
      res.std_v  = root[15:0];
      res.count  = run_count;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("response %0d: %s expected %h, got %h", responses_seen, name,
                     exp_v, act_v);
      end
   endtask

   // sample handshakes, compare responses, predict each accepted request
   always @(posedge clock) begin
      stats_type exp_s;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            responses_seen++;
            if (expected_stats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("response %0d arrived with no request outstanding", responses_seen);
            end else begin
               exp_s = expected_stats.pop_front();
               check_field("min_value", exp_s.min_v, rsp_tdata[15:0]);
               check_field("max_value", exp_s.max_v, rsp_tdata[31:16]);
               check_field("mean_value", exp_s.mean_v, rsp_tdata[47:32]);
               check_field("std_value", exp_s.std_v, rsp_tdata[63:48]);
               check_field("sample_count", exp_s.count, rsp_tdata[64 +: CNT_BITS]);
               check_field("count_full", exp_s.full, rsp_tuser[0]);
            end
         end
         if (req_tvalid && req_tready) begin
            accumulate_sample(req_tdata, exp_s);
            expected_stats.push_back(exp_s);
            samples_taken++;
         end
      end
   end

   // drive requests and response backpressure on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= idle_pct(samples_taken, 1))
            begin
               req_tvalid <= 1'b1;
               req_tdata  <= sample_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct(responses_seen, 0));
      end
   end

   initial begin
      int pick;
      int center;
      int v;
      // ramp min and max, negative sums that truncate toward zero, then the extremes
      sample_queue = '{16'h0100, 16'h0200, 16'hFE80, 16'h0000, 16'hFFFF, 16'h0001,
                       16'hFFFD, 16'hFFFE, 16'hFFFD, 16'h7FFF, 16'h8000, 16'h7FFF,
                       16'h8000, 16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA, 16'h0000,
                       16'h0000, 16'hFFFF};
      center = 0;
      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         if (i % 50 == 0) center = int'($urandom_range(65535)) - 32768;
         pick = $urandom_range(99);
         if (pick < 40) begin
            v = $urandom_range(65535);
         end else if (pick < 70) begin
            // tight cluster keeps the spread small for a while
            v = center + int'($urandom_range(64)) - 32;
         end else if (pick < 85) begin
            case ($urandom_range(3))
               0: v = 32767;
               1: v = -32768;
               2: v = 32766;
               default: v = -32767;
            endcase
         end else begin
            v = int'($urandom_range(16)) - 8;
         end
         sample_queue.push_back(v[15:0]);
      end
      total_samples = sample_queue.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (sample_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d samples across three flow-control phases, %0d responses checked",
               samples_taken, responses_seen);
      $display("Final count %0d, min %0d, max %0d, field errors %0d",
               run_count, run_min, run_max, mismatch_count);
      if (mismatch_count == 0 && expected_stats.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(12 * 1_200_000);
      $display("timeout with %0d responses still outstanding", expected_stats.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
